FILE: hw/rtl/hwsl_pkg.sv
// ----------------------------------------------------------------------------
// hwsl_pkg
// Shared types and constants of the heartbeat watchdog with status LEDs.
// ----------------------------------------------------------------------------
package hwsl_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int AGE_WIDTH    = 16;
    localparam int PHASE_WIDTH  = 16;
    localparam int DUR_WIDTH    = 16;
    localparam int CH_WIDTH     = 3;
    localparam int MASK_WIDTH   = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Reset values of the configuration registers.
    localparam logic [DUR_WIDTH-1:0] RST_TIMEOUT     = DUR_WIDTH'(100);
    localparam logic [DUR_WIDTH-1:0] RST_GOOD_ON     = DUR_WIDTH'(1425);
    localparam logic [DUR_WIDTH-1:0] RST_GOOD_OFF    = DUR_WIDTH'(75);
    localparam logic [DUR_WIDTH-1:0] RST_FAIL_HALF   = DUR_WIDTH'(75);
    localparam logic [DUR_WIDTH-1:0] RST_YELLOW_HALF = DUR_WIDTH'(250);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT     = 3'd0,
        CFG_GOOD_ON     = 3'd1,
        CFG_GOOD_OFF    = 3'd2,
        CFG_FAIL_HALF   = 3'd3,
        CFG_YELLOW_EN   = 3'd4,
        CFG_YELLOW_HALF = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK      = 1'b0,
        OP_HEARTBEAT = 1'b1
    } t_op;

    typedef struct packed {
        logic                operation;
        logic [CH_WIDTH-1:0] channel;
        logic                alive;
    } t_in_item;

    typedef struct packed {
        logic                  all_good;
        logic [MASK_WIDTH-1:0] fail_mask;
        logic                  green_led;
        logic                  yellow_led;
    } t_out_item;

endpackage

FILE: hw/rtl/heartbeat_watchdog_status_led_core.sv
// ----------------------------------------------------------------------------
// heartbeat_watchdog_status_led_core
// Per-channel heartbeat age tracking with a failure mask and two blinking
// status LEDs, one status beat per input beat.
// ----------------------------------------------------------------------------
// The status beat is registered: it is valid in the cycle after its input beat is taken.
// Throughput: one input beat per cycle; the result register frees itself in
// the same cycle it is taken, so only output backpressure slows the block.
// Reset: synchronous, active low; ages, LED levels and phases clear to zero and
// the configuration registers load their default values.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_status_led_core
    import hwsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [AGE_WIDTH-1:0]   AGE_MAX   = {AGE_WIDTH{1'b1}};
    localparam logic [PHASE_WIDTH-1:0] PHASE_MAX = {PHASE_WIDTH{1'b1}};

    // Configuration registers.
    logic [DUR_WIDTH-1:0] r_timeout;
    logic [DUR_WIDTH-1:0] r_good_on;
    logic [DUR_WIDTH-1:0] r_good_off;
    logic [DUR_WIDTH-1:0] r_fail_half;
    logic                 r_yellow_en;
    logic [DUR_WIDTH-1:0] r_yellow_half;

    // Watchdog state.
    logic [AGE_WIDTH-1:0]   r_age [NUM_CHANNELS];
    logic [AGE_WIDTH-1:0]   n_age [NUM_CHANNELS];
    logic                   r_green_on,     n_green_on;
    logic [PHASE_WIDTH-1:0] r_green_phase,  n_green_phase;
    logic                   r_yellow_on,    n_yellow_on;
    logic [PHASE_WIDTH-1:0] r_yellow_phase, n_yellow_phase;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_data, n_out_data;

    logic                    in_fire;
    logic                    is_tick;
    logic [NUM_CHANNELS-1:0] fail_vec;
    logic                    all_good;
    logic [DUR_WIDTH-1:0]    green_dur;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;
    assign is_tick     = (i_in_data.operation == OP_TICK);

    // Ages advance on a tick; a live heartbeat on a valid channel clears one.
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_age[i] = r_age[i];
            if (is_tick) begin
                if (r_age[i] != AGE_MAX) begin
                    n_age[i] = r_age[i] + AGE_WIDTH'(1);
                end
            end else if (i_in_data.alive && (int'(i_in_data.channel) == i)) begin
                n_age[i] = '0;
            end
            fail_vec[i] = (n_age[i] > AGE_WIDTH'(r_timeout));
        end
    end

    assign all_good = ~|fail_vec;

    always_comb begin
        if (all_good) begin
            green_dur = r_green_on ? r_good_on : r_good_off;
        end else begin
            green_dur = r_fail_half;
        end
    end

    // LED blinkers only move on ticks; yellow is forced off while disabled.
    always_comb begin
        n_green_on     = r_green_on;
        n_green_phase  = r_green_phase;
        n_yellow_on    = r_yellow_on;
        n_yellow_phase = r_yellow_phase;
        if (is_tick) begin
            if (r_green_phase >= PHASE_WIDTH'(green_dur)) begin
                n_green_on    = !r_green_on;
                n_green_phase = '0;
            end else if (r_green_phase != PHASE_MAX) begin
                n_green_phase = r_green_phase + PHASE_WIDTH'(1);
            end
            if (r_yellow_en && (r_yellow_phase >= PHASE_WIDTH'(r_yellow_half))) begin
                n_yellow_on    = !r_yellow_on;
                n_yellow_phase = '0;
            end else if (r_yellow_phase != PHASE_MAX) begin
                n_yellow_phase = r_yellow_phase + PHASE_WIDTH'(1);
            end
        end
        if (!r_yellow_en) begin
            n_yellow_on = 1'b0;
        end
    end

    always_comb begin
        n_out_data            = '0;
        n_out_data.all_good   = all_good;
        n_out_data.green_led  = n_green_on;
        n_out_data.yellow_led = n_yellow_on;
        for (int i = 0; i < MASK_WIDTH; i++) begin
            if (i < NUM_CHANNELS) begin
                n_out_data.fail_mask[i] = fail_vec[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= RST_TIMEOUT;
            r_good_on     <= RST_GOOD_ON;
            r_good_off    <= RST_GOOD_OFF;
            r_fail_half   <= RST_FAIL_HALF;
            r_yellow_en   <= 1'b0;
            r_yellow_half <= RST_YELLOW_HALF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT:     r_timeout     <= i_cfg_data;
                CFG_GOOD_ON:     r_good_on     <= i_cfg_data;
                CFG_GOOD_OFF:    r_good_off    <= i_cfg_data;
                CFG_FAIL_HALF:   r_fail_half   <= i_cfg_data;
                CFG_YELLOW_EN:   r_yellow_en   <= i_cfg_data[0];
                CFG_YELLOW_HALF: r_yellow_half <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_age[i] <= '0;
            end
            r_green_on     <= 1'b0;
            r_green_phase  <= '0;
            r_yellow_on    <= 1'b0;
            r_yellow_phase <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_age[i] <= n_age[i];
                end
                r_green_on     <= n_green_on;
                r_green_phase  <= n_green_phase;
                r_yellow_on    <= n_yellow_on;
                r_yellow_phase <= n_yellow_phase;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
